// ===== design/ssac_pkg.sv =====
// ssac_pkg: shared sizes, types and register codes of the sensor spike/stuck/absent checker.
// Used by every module of the block except the generic RAM.
package ssac_pkg;

   localparam int SLOTS      = 8;
   localparam int WINDOW     = 8;
   localparam int VALUE_BITS = 16;

   localparam int SLOT_FW  = 3;                               // slot field width
   localparam int SLOT_AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int WIN_AW   = $clog2(WINDOW);
   localparam int FILL_W   = $clog2(WINDOW + 1);
   localparam int WRAM_AW  = $clog2(SLOTS * WINDOW);
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 15;
   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 32;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   typedef enum logic [CSR_IW-1:0] {
      CSR_SLOT_COUNT = 3'd0,
      CSR_SPIKE_TEMP = 3'd1,
      CSR_SPIKE_HUM  = 3'd2,
      CSR_HUM_MASK   = 3'd3,
      CSR_EPSILON    = 3'd4,
      CSR_TIMEOUT    = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [3:0]         slot_count;
      logic [LIMIT_W-1:0] spike_limit_temp;
      logic [LIMIT_W-1:0] spike_limit_hum;
      logic [7:0]         humidity_slot_mask;
      logic [LIMIT_W-1:0] change_epsilon;
      logic [TIME_W-1:0]  stuck_timeout;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      slot_count:         4'd0,
      spike_limit_temp:   15'd200,
      spike_limit_hum:    15'd1000,
      humidity_slot_mask: 8'd0,
      change_epsilon:     15'd1,
      stuck_timeout:      32'd3600
   };

   typedef struct packed {
      logic               operation;
      logic [SLOT_FW-1:0] slot;
      value_type          sample;
      logic [TIME_W-1:0]  now_seconds;
      logic               time_valid;
   } item_type;

   localparam logic OP_READING   = 1'b0;
   localparam logic OP_NO_ANSWER = 1'b1;

   // per-slot record kept in the slot RAM
   typedef struct packed {
      logic [WIN_AW-1:0] pos;
      logic [FILL_W-1:0] fill;
      value_type         held;
      logic [TIME_W-1:0] ctime;
      logic              seen;
      logic              spike;
      logic              stuck;
      logic              absent;
   } slot_rec_type;

   typedef struct packed {
      logic      state_changed;
      logic      reliable;
      value_type passed_value;
      logic      spike_flag;
      logic      stuck_flag;
      logic      absent_flag;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SLOT,
      ST_SCAN,
      ST_EVAL
   } seq_state_type;

   function automatic logic [WRAM_AW-1:0] win_addr(input logic [SLOT_FW-1:0] slot,
                                                   input logic [WIN_AW-1:0] idx);
      win_addr = WRAM_AW'(int'(slot) * WINDOW + int'(idx));
   endfunction

endpackage

// ===== design/ssac_req_if.sv =====
// ssac_req_if: request channel (valid/ready plus one input word).
// Depends on ssac_pkg for the value type.
interface ssac_req_if import ssac_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               operation;
   logic [SLOT_FW-1:0] slot;
   value_type          sample;
   logic [TIME_W-1:0]  now_seconds;
   logic               time_valid;

   modport source (output valid, operation, slot, sample, now_seconds, time_valid,
                   input ready);
   modport sink   (input valid, operation, slot, sample, now_seconds, time_valid,
                   output ready);
endinterface

// ===== design/ssac_rsp_if.sv =====
// ssac_rsp_if: result channel (valid/ready plus one result word).
// Depends on ssac_pkg for the value type.
interface ssac_rsp_if import ssac_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      state_changed;
   logic      reliable;
   value_type passed_value;
   logic      spike_flag;
   logic      stuck_flag;
   logic      absent_flag;

   modport source (output valid, state_changed, reliable, passed_value, spike_flag,
                   stuck_flag, absent_flag, input ready);
   modport sink   (input valid, state_changed, reliable, passed_value, spike_flag,
                   stuck_flag, absent_flag, output ready);
endinterface

// ===== design/sensor_spike_stuck_absent_check.sv =====
// sensor_spike_stuck_absent_check: top level of the sensor spike/stuck/absent checker.
// Depends on ssac_pkg, ssac_req_if, ssac_rsp_if, ssac_csr, ssac_seq.
//
//  channel  | dir | handshake            | word
//  ---------+-----+----------------------+-----------------------------------------------
//  req_ch   | in  | valid/ready          | operation, slot, sample, now_seconds, time_valid
//  rsp_ch   | out | valid/ready          | state_changed, reliable, passed_value, flags
//  csr_*    | in  | csr_we, no back-off  | csr_index, csr_wdata (write only)
//
// Flow: one word in flight. A reading that fills its slot's window goes through accept,
//   slot RAM read, a window RAM scan over all WINDOW entries and evaluate; other in-use
//   words skip the scan, out-of-use slots also skip the slot RAM read. The window scan
//   runs through the single window RAM read port.
// Reset: synchronous, active high; slot records read as zero until first written
//   (per-slot valid bits), so no clearing pass is needed.
// Stalls: the result sits in an output register; the next word is accepted while it
//   waits, and processing holds in the evaluate step until the register frees up.
module sensor_spike_stuck_absent_check import ssac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ssac_req_if.sink          req_ch,
   ssac_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata
);

   cfg_type cfg;

   // configuration registers; the user must write them only while the block is idle, the block does not enforce it
   ssac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: slot RAM read-modify-write, window RAM push and min/max scan
   ssac_seq u_seq (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

endmodule

// ===== design/ssac_ram.sv =====
// ssac_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ssac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/ssac_csr.sv =====
// ssac_csr: configuration register file, write-only.
// Depends on ssac_pkg (cfg_type, register codes, reset values).
module ssac_csr import ssac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output cfg_type           cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_COUNT: cfg_in.slot_count         = csr_wdata[3:0];
            CSR_SPIKE_TEMP: cfg_in.spike_limit_temp   = csr_wdata[LIMIT_W-1:0];
            CSR_SPIKE_HUM:  cfg_in.spike_limit_hum    = csr_wdata[LIMIT_W-1:0];
            CSR_HUM_MASK:   cfg_in.humidity_slot_mask = csr_wdata[7:0];
            CSR_EPSILON:    cfg_in.change_epsilon     = csr_wdata[LIMIT_W-1:0];
            CSR_TIMEOUT:    cfg_in.stuck_timeout      = csr_wdata[TIME_W-1:0];
            default:        cfg_in = cfg_ff;          // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/ssac_seq.sv =====
// ssac_seq: sequencer and datapath around the slot RAM and the window RAM.
// Depends on ssac_pkg, ssac_ram, ssac_req_if, ssac_rsp_if.
module ssac_seq import ssac_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   ssac_req_if.sink   req,
   ssac_rsp_if.source rsp
);

   localparam int SLOT_RW = $bits(slot_rec_type);

   seq_state_type state_ff, state_in;
   item_type      item_ff, item_in;
   logic          in_use_ff, in_use_in;
   slot_rec_type  rec_ff, rec_in;
   logic          chg_ff, chg_in;
   logic          clk_ok_ff, clk_ok_in;
   logic [TIME_W-1:0] elapsed_ff, elapsed_in;
   logic [FILL_W-1:0] scan_cnt_ff, scan_cnt_in;
   value_type     lo_ff, lo_in, hi_ff, hi_in;
   logic [SLOTS-1:0] slot_vld_ff, slot_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_ff, rsp_in;

   // RAM ports
   logic               sram_we, sram_re;
   logic [SLOT_AW-1:0] sram_waddr, sram_raddr;
   logic [SLOT_RW-1:0] sram_rdata;
   slot_rec_type       sram_wdata;
   logic               wram_we, wram_re;
   logic [WRAM_AW-1:0] wram_waddr, wram_raddr;
   value_type          wram_rdata;

   // combinational helpers
   logic               accept;
   logic [SLOT_AW-1:0] slot_addr;
   slot_rec_type       rd_rec, new_rec;
   logic [FILL_W-1:0]  fill_rd_next, fill_ev_next;
   logic               full_rd, full_ev;
   logic signed [VALUE_BITS:0] diff;
   logic [VALUE_BITS:0]        abs_diff;
   logic [TIME_W:0]            elapsed_wide;
   logic [VALUE_BITS:0]        spread;
   logic [LIMIT_W-1:0]         limit;
   logic               reliable;
   logic               out_free;
   logic               rsp_load;
   result_type         result;

   ssac_ram #(.WIDTH(SLOT_RW), .DEPTH(SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (sram_we),
      .waddr (sram_waddr),
      .wdata (sram_wdata),
      .re    (sram_re),
      .raddr (sram_raddr),
      .rdata (sram_rdata)
   );

   ssac_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS * WINDOW)) u_win_ram (
      .clock (clock),
      .we    (wram_we),
      .waddr (wram_waddr),
      .wdata (item_ff.sample),
      .re    (wram_re),
      .raddr (wram_raddr),
      .rdata (wram_rdata)
   );

   assign accept    = req.valid && req.ready;
   assign slot_addr = SLOT_AW'(item_ff.slot);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // record as read; never-written slots read as the reset record
   assign rd_rec = slot_vld_ff[slot_addr] ? slot_rec_type'(sram_rdata) : '0;

   assign fill_rd_next = (rd_rec.fill < FILL_W'(WINDOW)) ? rd_rec.fill + 1'b1 : rd_rec.fill;
   assign full_rd      = (fill_rd_next == FILL_W'(WINDOW));
   assign fill_ev_next = (rec_ff.fill < FILL_W'(WINDOW)) ? rec_ff.fill + 1'b1 : rec_ff.fill;
   assign full_ev      = (fill_ev_next == FILL_W'(WINDOW));

   assign diff     = {item_ff.sample[VALUE_BITS-1], item_ff.sample}
                   - {rd_rec.held[VALUE_BITS-1], rd_rec.held};
   assign abs_diff = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
   assign elapsed_wide = {1'b0, item_ff.now_seconds} - {1'b0, rd_rec.ctime};

   assign spread = {hi_ff[VALUE_BITS-1], hi_ff} - {lo_ff[VALUE_BITS-1], lo_ff};
   assign limit  = cfg.humidity_slot_mask[item_ff.slot] ? cfg.spike_limit_hum
                                                        : cfg.spike_limit_temp;

   // updated record and result, from registered state only
   always_comb begin
      new_rec = rec_ff;
      if (item_ff.operation == OP_NO_ANSWER) begin
         new_rec.absent = 1'b1;
      end else begin
         new_rec.absent = 1'b0;
         new_rec.pos    = (rec_ff.pos == WIN_AW'(WINDOW - 1)) ? '0 : rec_ff.pos + 1'b1;
         new_rec.fill   = fill_ev_next;
         new_rec.spike  = full_ev && (spread > (VALUE_BITS+1)'(limit));
         if (item_ff.time_valid) begin
            if (chg_ff) begin
               new_rec.held  = item_ff.sample;
               new_rec.ctime = item_ff.now_seconds;
               new_rec.seen  = 1'b1;
               new_rec.stuck = 1'b0;
            end else if (clk_ok_ff && (elapsed_ff >= cfg.stuck_timeout)) begin
               new_rec.stuck = 1'b1;
            end
         end
      end
      reliable = (item_ff.operation == OP_READING) && !new_rec.spike && !new_rec.stuck;

      result = '0;
      if (in_use_ff) begin
         result.state_changed = (new_rec.spike != rec_ff.spike)
                             || (new_rec.stuck != rec_ff.stuck)
                             || (new_rec.absent != rec_ff.absent);
         result.reliable      = reliable;
         result.passed_value  = reliable ? item_ff.sample : '0;
         result.spike_flag    = new_rec.spike;
         result.stuck_flag    = new_rec.stuck;
         result.absent_flag   = new_rec.absent;
      end
   end

   // next state and RAM control
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      in_use_in    = in_use_ff;
      rec_in       = rec_ff;
      chg_in       = chg_ff;
      clk_ok_in    = clk_ok_ff;
      elapsed_in   = elapsed_ff;
      scan_cnt_in  = scan_cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      slot_vld_in  = slot_vld_ff;
      rsp_in       = rsp_ff;
      rsp_load     = 1'b0;
      req.ready    = 1'b0;
      sram_re      = 1'b0;
      sram_raddr   = SLOT_AW'(req.slot);
      sram_we      = 1'b0;
      sram_waddr   = slot_addr;
      sram_wdata   = new_rec;
      wram_we      = 1'b0;
      wram_waddr   = win_addr(item_ff.slot, rd_rec.pos);
      wram_re      = 1'b0;
      wram_raddr   = win_addr(item_ff.slot, scan_cnt_ff[WIN_AW-1:0]);

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               item_in   = '{operation:   req.operation,
                             slot:        req.slot,
                             sample:      req.sample,
                             now_seconds: req.now_seconds,
                             time_valid:  req.time_valid};
               in_use_in = (4'(req.slot) < cfg.slot_count) && (int'(req.slot) < SLOTS);
               sram_re   = 1'b1;
               state_in  = in_use_in ? ST_SLOT : ST_EVAL;
            end
         end
         ST_SLOT: begin
            rec_in      = rd_rec;
            chg_in      = !rd_rec.seen
                       || (abs_diff >= (VALUE_BITS+1)'(cfg.change_epsilon));
            clk_ok_in   = !elapsed_wide[TIME_W];
            elapsed_in  = elapsed_wide[TIME_W-1:0];
            scan_cnt_in = '0;
            if (item_ff.operation == OP_READING) begin
               wram_we  = 1'b1;
               state_in = full_rd ? ST_SCAN : ST_EVAL;
            end else begin
               state_in = ST_EVAL;
            end
         end
         ST_SCAN: begin
            // read entry cnt, fold in entry cnt-1
            wram_re = (scan_cnt_ff < FILL_W'(WINDOW));
            if (scan_cnt_ff == FILL_W'(1)) begin
               lo_in = wram_rdata;
               hi_in = wram_rdata;
            end else if (scan_cnt_ff != '0) begin
               lo_in = (wram_rdata < lo_ff) ? wram_rdata : lo_ff;
               hi_in = (wram_rdata > hi_ff) ? wram_rdata : hi_ff;
            end
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == FILL_W'(WINDOW)) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = result;
               if (in_use_ff) begin
                  sram_we                = 1'b1;
                  slot_vld_in[slot_addr] = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = rsp_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         scan_cnt_ff  <= '0;
         in_use_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_vld_ff  <= slot_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_cnt_ff  <= scan_cnt_in;
         in_use_ff    <= in_use_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      rec_ff     <= rec_in;
      chg_ff     <= chg_in;
      clk_ok_ff  <= clk_ok_in;
      elapsed_ff <= elapsed_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.state_changed = rsp_ff.state_changed;
   assign rsp.reliable      = rsp_ff.reliable;
   assign rsp.passed_value  = rsp_ff.passed_value;
   assign rsp.spike_flag    = rsp_ff.spike_flag;
   assign rsp.stuck_flag    = rsp_ff.stuck_flag;
   assign rsp.absent_flag   = rsp_ff.absent_flag;

   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SLOT || state_ff == ST_EVAL))
      else $error("accepted word did not start processing");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_cnt_ff <= FILL_W'(WINDOW)))
      else $error("window scan ran past the window");

   a_writeback_with_result: assert property (@(posedge clock) disable iff (reset)
      sram_we |=> (state_ff == ST_IDLE && rsp.valid))
      else $error("slot write-back without a result word");

   a_unused_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !in_use_ff) |=> (!rsp.state_changed && !rsp.reliable
         && rsp.passed_value == '0 && !rsp.spike_flag && !rsp.stuck_flag
         && !rsp.absent_flag))
      else $error("out-of-use slot gave a nonzero result");

   a_no_scan_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !sram_we && !wram_we)
      else $error("RAM write during window scan");

endmodule

// ===== bench/ssac_flag_check.sv =====
// ssac_flag_check: watches the request, result and register ports of the sensor checker,
// predicts each result word and compares it field by field. Depends on ssac_pkg and the
// ssac_req_if / ssac_rsp_if channel interfaces.
module ssac_flag_check import ssac_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ssac_req_if               req_mon,
   ssac_rsp_if               rsp_mon,
   input  logic              csr_we,
   input  logic [CSR_IW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_wdata,
   output int                mismatch_count,
   output int                results_owed
);

   cfg_type           cfg;
   value_type         window_vals [SLOTS][WINDOW];
   logic [WIN_AW-1:0] window_head [SLOTS];
   int                window_depth [SLOTS];
   value_type         last_changed [SLOTS];
   logic [TIME_W-1:0] changed_at [SLOTS];
   logic              timed_once [SLOTS];
   logic              spike_on [SLOTS];
   logic              stuck_on [SLOTS];
   logic              absent_on [SLOTS];

   result_type        flag_results_due [$];
   item_type          taken;
   result_type        due;
   int                n;

   task automatic report_mismatch(input string what);
      $display("%0t ERROR %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic signed [31:0] got,
                              input logic signed [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Updates the slot table for one word and returns the result it must produce.
   function automatic result_type predict_flags(input item_type w);
      result_type        r;
      logic [SLOT_FW-1:0] s;
      int                used, lo, hi, limit, diff, i;
      logic              was_spike, was_stuck, was_absent, passed;
      r = '0;
      s = w.slot;
      used = (cfg.slot_count < SLOTS) ? int'(cfg.slot_count) : SLOTS;
      if (int'(s) >= used)
         return r;
      was_spike  = spike_on[s];
      was_stuck  = stuck_on[s];
      was_absent = absent_on[s];
      passed     = 1'b0;
      if (w.operation == OP_NO_ANSWER) begin
         absent_on[s] = 1'b1;
      end else begin
         absent_on[s] = 1'b0;
         window_vals[s][window_head[s]] = w.sample;
         window_head[s] = WIN_AW'((int'(window_head[s]) + 1) % WINDOW);
         if (window_depth[s] < WINDOW)
            window_depth[s]++;
         if (window_depth[s] >= WINDOW) begin
            lo = window_vals[s][0];
            hi = lo;
            for (i = 1; i < WINDOW; i++) begin
               if (window_vals[s][i] < lo) lo = window_vals[s][i];
               if (window_vals[s][i] > hi) hi = window_vals[s][i];
            end
            limit = cfg.humidity_slot_mask[s] ? int'(cfg.spike_limit_hum)
                                              : int'(cfg.spike_limit_temp);
            spike_on[s] = (hi - lo) > limit;
         end else begin
            spike_on[s] = 1'b0;
         end
         if (w.time_valid) begin
            diff = int'(w.sample) - int'(last_changed[s]);
            if (diff < 0) diff = -diff;
            if (!timed_once[s] || diff >= int'(cfg.change_epsilon)) begin
               last_changed[s] = w.sample;
               changed_at[s]   = w.now_seconds;
               timed_once[s]   = 1'b1;
               stuck_on[s]     = 1'b0;
            end else if (w.now_seconds >= changed_at[s] &&
                         (w.now_seconds - changed_at[s]) >= cfg.stuck_timeout) begin
               stuck_on[s] = 1'b1;
            end
         end
         passed = !spike_on[s] && !stuck_on[s];
      end
      r.state_changed = (spike_on[s] != was_spike) || (stuck_on[s] != was_stuck) ||
                        (absent_on[s] != was_absent);
      r.reliable      = passed;
      r.passed_value  = passed ? w.sample : '0;
      r.spike_flag    = spike_on[s];
      r.stuck_flag    = stuck_on[s];
      r.absent_flag   = absent_on[s];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg = CFG_RESET;
         for (n = 0; n < SLOTS; n++) begin
            window_head[n]  = '0;
            window_depth[n] = 0;
            last_changed[n] = '0;
            changed_at[n]   = '0;
            timed_once[n]   = 1'b0;
            spike_on[n]     = 1'b0;
            stuck_on[n]     = 1'b0;
            absent_on[n]    = 1'b0;
         end
         flag_results_due.delete();
         mismatch_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_SLOT_COUNT: cfg.slot_count         = csr_wdata[3:0];
               CSR_SPIKE_TEMP: cfg.spike_limit_temp   = csr_wdata[LIMIT_W-1:0];
               CSR_SPIKE_HUM:  cfg.spike_limit_hum    = csr_wdata[LIMIT_W-1:0];
               CSR_HUM_MASK:   cfg.humidity_slot_mask = csr_wdata[7:0];
               CSR_EPSILON:    cfg.change_epsilon     = csr_wdata[LIMIT_W-1:0];
               CSR_TIMEOUT:    cfg.stuck_timeout      = csr_wdata[TIME_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            taken.operation   = req_mon.operation;
            taken.slot        = req_mon.slot;
            taken.sample      = req_mon.sample;
            taken.now_seconds = req_mon.now_seconds;
            taken.time_valid  = req_mon.time_valid;
            flag_results_due.push_back(predict_flags(taken));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (flag_results_due.size() == 0) begin
               report_mismatch("result word with none expected");
            end else begin
               due = flag_results_due.pop_front();
               check_field("state_changed", rsp_mon.state_changed, due.state_changed);
               check_field("reliable", rsp_mon.reliable, due.reliable);
               check_field("passed_value", rsp_mon.passed_value, due.passed_value);
               check_field("spike_flag", rsp_mon.spike_flag, due.spike_flag);
               check_field("stuck_flag", rsp_mon.stuck_flag, due.stuck_flag);
               check_field("absent_flag", rsp_mon.absent_flag, due.absent_flag);
            end
         end
      end
      results_owed <= flag_results_due.size();
   end

endmodule

// ===== bench/sensor_spike_stuck_absent_check_tb.sv =====
// sensor_spike_stuck_absent_check_tb: drives words and register settings into the sensor
// checker and gives the verdict. Depends on ssac_pkg, the channel interfaces, the block
// and the ssac_flag_check module, which does all prediction and comparison.
module sensor_spike_stuck_absent_check_tb;
   import ssac_pkg::*;

   localparam int SETTLE_CYCLES   = 16;    // a bit over the worst-case latency
   localparam int HOLD_OFF_CYCLES = 150;   // long receiver stall, fills the block
   localparam int RUN_LIMIT       = 2_000_000;

   // receiver behaviors, one per stretch
   typedef enum int {
      DRAIN_FREE,
      DRAIN_COIN,
      DRAIN_EVERY_4TH,
      DRAIN_MOSTLY
   } drain_mode_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_DW-1:0] csr_wdata;

   ssac_req_if req_ch ();
   ssac_rsp_if rsp_ch ();

   int      mismatch_count;
   int      results_owed;
   bit      hold_off_request = 1'b0;

   // stimulus-side view of the settings, only used to shape the random words
   cfg_type           active_cfg = CFG_RESET;
   int                last_sample [SLOTS];
   logic [TIME_W-1:0] clock_now = 32'd1000;

   sensor_spike_stuck_absent_check u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ssac_flag_check u_flag_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Safety net: far beyond the slowest legal run.
   initial begin
      #(RUN_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Word and register helpers
   // ---------------------------------------------------------------------

   function automatic item_type word_of(input logic op, input int slot, input int sample,
                                        input logic [TIME_W-1:0] now, input logic tv);
      item_type w;
      w.operation   = op;
      w.slot        = SLOT_FW'(slot);
      w.sample      = value_type'(sample);
      w.now_seconds = now;
      w.time_valid  = tv;
      return w;
   endfunction

   // Offers one word and returns after the edge that accepts it. valid stays high,
   // so back-to-back words need no lowering in between.
   task automatic send_word(input item_type w);
      req_ch.valid       <= 1'b1;
      req_ch.operation   <= w.operation;
      req_ch.slot        <= w.slot;
      req_ch.sample      <= w.sample;
      req_ch.now_seconds <= w.now_seconds;
      req_ch.time_valid  <= w.time_valid;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Drops valid and waits until every predicted word has come back; the extra
   // cycles cover the block still winding down after its last result.
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DW-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_settings(input cfg_type c);
      write_reg(CSR_SLOT_COUNT, CSR_DW'(c.slot_count));
      write_reg(CSR_SPIKE_TEMP, CSR_DW'(c.spike_limit_temp));
      write_reg(CSR_SPIKE_HUM, CSR_DW'(c.spike_limit_hum));
      write_reg(CSR_HUM_MASK, CSR_DW'(c.humidity_slot_mask));
      write_reg(CSR_EPSILON, CSR_DW'(c.change_epsilon));
      write_reg(CSR_TIMEOUT, CSR_DW'(c.stuck_timeout));
      csr_we <= 1'b0;
      active_cfg = c;
   endtask

   // Settings per phase: the fixed ones hit the register extremes, the rest roam.
   function automatic cfg_type phase_settings(input int phase);
      cfg_type c;
      c.slot_count         = 4'($urandom_range(1, 15));
      c.spike_limit_temp   = LIMIT_W'($urandom_range(0, 3000));
      c.spike_limit_hum    = LIMIT_W'($urandom_range(0, 3000));
      c.humidity_slot_mask = 8'($urandom_range(0, 255));
      c.change_epsilon     = LIMIT_W'($urandom_range(0, 50));
      c.stuck_timeout      = TIME_W'($urandom_range(0, 40));
      case (phase)
         0: c = '{4'd6, 15'd200, 15'd1000, 8'hA5, 15'd1, 32'd10};
         1: c = '{4'd8, 15'd300, 15'd1500, 8'h0F, 15'd2, 32'd5};
         2: c = '{4'd15, 15'd0, 15'd32767, 8'hFF, 15'd0, 32'd0};
         3: c = '{4'd3, 15'd32767, 15'd0, 8'h00, 15'd32767, 32'hFFFF_FFFF};
         4: c.slot_count = 4'd0;                    // nothing in use
         default: ;
      endcase
      return c;
   endfunction

   // Mostly plausible sensor traffic per slot: repeats (stuck), small wobble around
   // epsilon, bigger swings around the spread limits, now and then a wild value.
   // Time mostly creeps forward, sometimes jumps or goes back. A share is pure noise.
   function automatic item_type random_word();
      item_type w;
      int       used, pick, span, val;
      used = (active_cfg.slot_count < SLOTS) ? int'(active_cfg.slot_count) : SLOTS;
      if ($urandom_range(0, 99) < 10) begin
         w = item_type'({$urandom, $urandom});
         return w;
      end
      w.operation = ($urandom_range(0, 99) < 8) ? OP_NO_ANSWER : OP_READING;
      if (used > 0 && $urandom_range(0, 9) != 0)
         w.slot = SLOT_FW'($urandom_range(0, used - 1));
      else
         w.slot = SLOT_FW'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         val = last_sample[w.slot];
      end else if (pick < 95) begin
         span = (pick < 80) ? int'(active_cfg.change_epsilon) + 2 : 800;
         val  = $urandom_range(0, 2 * span);
         val  = last_sample[w.slot] + val - span;
      end else begin
         val = $urandom_range(0, 65535);
         val = val - 32768;
      end
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      last_sample[w.slot] = val;
      w.sample = value_type'(val);
      pick = $urandom_range(0, 99);
      if (pick < 3)
         clock_now = clock_now - TIME_W'($urandom_range(1, 200));
      else if (pick < 6)
         clock_now = clock_now + TIME_W'($urandom);
      else
         clock_now = clock_now + TIME_W'($urandom_range(0, 4));
      w.now_seconds = clock_now;
      w.time_valid  = ($urandom_range(0, 9) != 0);
      return w;
   endfunction

   // Random words in bursts with random gaps. With squeeze set, the receiver is asked
   // to hold off a third of the way in while words keep coming, and at two thirds the
   // sender stops until every result is back.
   task automatic run_phase(input int words, input bit squeeze);
      int sent, burst, gap, b;
      sent = 0;
      while (sent < words) begin
         burst = $urandom_range(1, 24);
         for (b = 0; b < burst && sent < words; b++) begin
            send_word(random_word());
            sent++;
            if (squeeze && sent == words / 3)
               hold_off_request = 1'b1;
            if (squeeze && sent == 2 * words / 3)
               wait_idle();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stretches of differing stall behavior, plus the long hold-off
   // ---------------------------------------------------------------------
   initial begin : drain_side
      drain_mode_type mode;
      int             stretch, k;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            mode    = drain_mode_type'($urandom_range(0, 3));
            stretch = $urandom_range(10, 120);
            for (k = 0; k < stretch; k++) begin
               case (mode)
                  DRAIN_FREE:      rsp_ch.ready <= 1'b1;
                  DRAIN_COIN:      rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                  DRAIN_EVERY_4TH: rsp_ch.ready <= (k % 4 == 3);
                  default:         rsp_ch.ready <= ($urandom_range(0, 9) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: reset, directed words, random phases, verdict
   // ---------------------------------------------------------------------
   initial begin : source_side
      int phase, n;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.operation   = OP_READING;
      req_ch.slot        = '0;
      req_ch.sample      = '0;
      req_ch.now_seconds = '0;
      req_ch.time_valid  = 1'b0;
      for (n = 0; n < SLOTS; n++)
         last_sample[n] = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // slot count out of reset is zero: every slot out of use, all-zero results
      send_word(word_of(OP_READING, 0, 1234, 32'd0, 1'b1));
      send_word(word_of(OP_NO_ANSWER, 7, 0, 32'd0, 1'b0));
      wait_idle();

      // six slots, slots 0/2/5/7 on the humidity limit, timeout 10 s
      write_settings(phase_settings(0));
      // no response twice: absent rises, then no change
      send_word(word_of(OP_NO_ANSWER, 0, 0, 32'd0, 1'b0));
      send_word(word_of(OP_NO_ANSWER, 0, 0, 32'd0, 1'b0));
      // first timed reading clears absent and only latches the held value
      send_word(word_of(OP_READING, 0, 32767, 32'd100, 1'b1));
      // full-scale swings; the eighth reading fills the window and raises spike
      for (n = 0; n < 7; n++)
         send_word(word_of(OP_READING, 0, (n % 2 == 0) ? -32768 : 32767,
                           32'd101 + n, 1'b1));
      // flat value: stuck once the timeout has passed
      send_word(word_of(OP_READING, 1, 500, 32'd1000, 1'b1));
      send_word(word_of(OP_READING, 1, 500, 32'd1005, 1'b1));
      send_word(word_of(OP_READING, 1, 500, 32'd1010, 1'b1));
      // time not valid: stuck and held value untouched despite a new value
      send_word(word_of(OP_READING, 1, 900, 32'd1011, 1'b0));
      // clock going back: no stuck
      send_word(word_of(OP_READING, 2, -200, 32'd5000, 1'b1));
      send_word(word_of(OP_READING, 2, -200, 32'd3, 1'b1));
      // slot at the slot count is out of use
      send_word(word_of(OP_READING, 6, -1, 32'hFFFF_FFFF, 1'b1));
      send_word(word_of(OP_READING, 5, -32768, 32'hFFFF_FFFF, 1'b1));
      // no response on a stuck slot
      send_word(word_of(OP_NO_ANSWER, 1, 0, 32'd0, 1'b0));
      wait_idle();

      for (phase = 1; phase <= 6; phase++) begin
         write_settings(phase_settings(phase));
         run_phase((active_cfg.slot_count == 0) ? 40 : 125, phase == 2);
         wait_idle();
      end

      if (mismatch_count == 0 && results_owed == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
